/* rtl/nor_flash_program_erase_model_top_defines.svh */
// Assertion macros for the checker file of the NOR flash emulation block
`ifndef NOR_FLASH_PROGRAM_ERASE_MODEL_TOP_DEFINES_SVH
`define NOR_FLASH_PROGRAM_ERASE_MODEL_TOP_DEFINES_SVH

// Property that holds in the same cycle as its trigger
`define NFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that holds in the cycle after its trigger
`define NFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/nfp_pkg.sv */
// Shared constants for the NOR flash program/erase emulation block
package nfp_pkg;

  localparam int unsigned CAPACITY_DEF  = 65536;
  localparam int unsigned MAX_BYTES_DEF = 8;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Byte value held by every location after reset
  localparam logic [7:0] ERASED_RESET = 8'hFF;

  // Operation codes
  localparam logic [1:0] FUNC_READ    = 2'd0;
  localparam logic [1:0] FUNC_PROGRAM = 2'd1;
  localparam logic [1:0] FUNC_ERASE   = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ERASED_VALUE   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRICT_PROGRAM = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_FAIL_INJECT    = 8'd2;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

/* rtl/nfp_mem.sv */
// Byte-wide flash array with registered read and a clearing pass after reset
module nfp_mem #(
  parameter int unsigned CAPACITY = nfp_pkg::CAPACITY_DEF,
  localparam int unsigned AddrW = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o,
  output logic             busy_o
);

  logic [7:0]       flash_mem [CAPACITY];
  logic [7:0]       rdata_q;
  logic [AddrW-1:0] clr_idx_q;
  logic             clearing_q;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;

  // The sweep owns the write port until every byte holds the reset value
  assign wr_en   = clearing_q | we_i;
  assign wr_addr = clearing_q ? clr_idx_q : addr_i;
  assign wr_data = clearing_q ? nfp_pkg::ERASED_RESET : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      if (clr_idx_q == AddrW'(CAPACITY - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flash_mem[wr_addr] <= wr_data;
    end
    rdata_q <= flash_mem[addr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing_q;

endmodule

/* rtl/nor_flash_program_erase_model_top.sv */
// NOR flash program/erase emulation: command sequencer around a byte memory
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | func, start_address, byte_count,
//           |           |                           | write_data
//   out     | output    | out_valid_o / out_stall_i | status, read_data, op_total
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One command at a time, one memory access per cycle through a single byte port.
// Rejected, zero-length or fault-injected commands go straight to the done state. A read
// requests and captures each byte in turn. A program reads every byte, checks, then writes
// each byte back, and ends after the check if it fails. An erase writes each byte in turn.
// After reset a clearing pass fills every byte of the array; in_stall_o is high meanwhile.
// A finished result waits in the output register; the next command is taken meanwhile.
module nor_flash_program_erase_model_top #(
  parameter int unsigned CAPACITY  = nfp_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_BYTES = nfp_pkg::MAX_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic [15:0]                  start_address_i,
  input  logic [16:0]                  byte_count_i,
  input  logic [63:0]                  write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [63:0]                  read_data_o,
  output logic [31:0]                  op_total_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nfp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    StIdle,
    StRdReq,
    StRdCap,
    StCheck,
    StWrite,
    StErase,
    StDone
  } state_e;

  state_e      state_q;
  logic        is_read_q;
  logic [15:0] base_q;
  logic [16:0] cnt_q;
  logic [16:0] idx_q;
  logic [63:0] wdata_q;
  logic [63:0] rbuf_q;
  logic        status_q;
  logic [31:0] op_count_q;

  logic [7:0]  erased_value_q;
  logic        strict_q;
  logic        fail_q;

  logic        out_valid_q;
  logic        out_status_q;
  logic [63:0] out_data_q;
  logic [31:0] out_total_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  logic             mem_busy;

  logic        in_accept;
  logic [17:0] in_end;
  logic        in_bad;
  logic [17:0] ptr;
  logic [16:0] idx_nx;
  logic        last_byte;
  logic [7:0]  lane_en;
  logic        violation;
  logic        out_free;

  assign in_stall_o = (state_q != StIdle) | mem_busy;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign in_end = {2'b00, start_address_i} + {1'b0, byte_count_i};
  assign in_bad = (func_i != nfp_pkg::FUNC_READ && func_i != nfp_pkg::FUNC_PROGRAM &&
                   func_i != nfp_pkg::FUNC_ERASE) ||
                  ({14'd0, in_end} > 32'(CAPACITY)) ||
                  (func_i != nfp_pkg::FUNC_ERASE && byte_count_i > 17'(MAX_BYTES));

  assign ptr       = {2'b00, base_q} + {1'b0, idx_q};
  assign idx_nx    = idx_q + 17'd1;
  assign last_byte = (idx_nx == cnt_q);

  // Strict check covers only the bytes named by the count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lane_en[i] = (17'(i) < cnt_q);
    end
    violation = 1'b0;
    for (int i = 0; i < 8; i++) begin
      violation = violation |
                  (lane_en[i] & (|(~rbuf_q[8*i +: 8] & wdata_q[8*i +: 8])));
    end
    violation = violation & strict_q;
  end

  always_comb begin
    mem_addr  = AddrW'(ptr);
    mem_we    = 1'b0;
    mem_wdata = erased_value_q;
    unique case (state_q)
      StWrite: begin
        mem_we    = 1'b1;
        mem_wdata = rbuf_q[8*idx_q[2:0] +: 8] & wdata_q[8*idx_q[2:0] +: 8];
      end
      StErase: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  nfp_mem #(
    .CAPACITY(CAPACITY)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata),
    .busy_o (mem_busy)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erased_value_q <= nfp_pkg::ERASED_RESET;
      strict_q       <= 1'b1;
      fail_q         <= 1'b0;
    end else if (cfg_valid_i) begin
      priority if (cfg_index_i == nfp_pkg::CFG_ERASED_VALUE) begin
        erased_value_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == nfp_pkg::CFG_STRICT_PROGRAM) begin
        strict_q <= cfg_data_i[0];
      end else if (cfg_index_i == nfp_pkg::CFG_FAIL_INJECT) begin
        fail_q <= cfg_data_i[0];
      end else begin
        fail_q <= fail_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      is_read_q    <= 1'b0;
      base_q       <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      wdata_q      <= '0;
      rbuf_q       <= '0;
      status_q     <= nfp_pkg::STATUS_OK;
      op_count_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= nfp_pkg::STATUS_OK;
      out_data_q   <= '0;
      out_total_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_accept) begin
            is_read_q <= (func_i == nfp_pkg::FUNC_READ);
            base_q    <= start_address_i;
            cnt_q     <= byte_count_i;
            idx_q     <= '0;
            wdata_q   <= write_data_i;
            rbuf_q    <= '0;
            status_q  <= (in_bad || (func_i != nfp_pkg::FUNC_READ && fail_q)) ?
                         nfp_pkg::STATUS_ERR : nfp_pkg::STATUS_OK;
            if (in_bad) begin
              state_q <= StDone;
            end else begin
              op_count_q <= op_count_q + 32'd1;
              priority if (func_i == nfp_pkg::FUNC_READ) begin
                state_q <= (byte_count_i != 17'd0) ? StRdReq : StDone;
              end else if (fail_q || byte_count_i == 17'd0) begin
                state_q <= StDone;
              end else if (func_i == nfp_pkg::FUNC_PROGRAM) begin
                state_q <= StRdReq;
              end else begin
                state_q <= StErase;
              end
            end
          end
        end
        StRdReq: begin
          state_q <= StRdCap;
        end
        StRdCap: begin
          rbuf_q[8*idx_q[2:0] +: 8] <= mem_rdata;
          if (last_byte) begin
            idx_q   <= '0;
            state_q <= is_read_q ? StDone : StCheck;
          end else begin
            idx_q   <= idx_nx;
            state_q <= StRdReq;
          end
        end
        StCheck: begin
          if (violation) begin
            status_q <= nfp_pkg::STATUS_ERR;
            state_q  <= StDone;
          end else begin
            state_q <= StWrite;
          end
        end
        StWrite, StErase: begin
          if (last_byte) begin
            state_q <= StDone;
          end else begin
            idx_q <= idx_nx;
          end
        end
        StDone: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_data_q   <= (is_read_q && status_q == nfp_pkg::STATUS_OK) ? rbuf_q : 64'd0;
            out_total_q  <= op_count_q;
            state_q      <= StIdle;
          end else begin
            out_valid_q <= out_valid_q;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_data_q;
  assign op_total_o  = out_total_q;

endmodule

/* rtl/nfp_chk.sv */
// Port-level assertions for the NOR flash emulation block, bound to the top level
`include "nor_flash_program_erase_model_top_defines.svh"

module nfp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [63:0] read_data_o,
  input logic [31:0] op_total_o
);

  `NFP_ASSERT_NXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `NFP_ASSERT_NXT(a_out_total_holds, out_valid_o && out_stall_i, $stable(op_total_o), "op_total changed while stalled")
  `NFP_ASSERT_IMP(a_err_no_data, out_valid_o && status_o, read_data_o == 64'd0, "error result carries read data")
  `NFP_ASSERT_NXT(a_one_request, in_valid_i && !in_stall_o, in_stall_o, "second request taken while busy")

endmodule

bind nor_flash_program_erase_model_top nfp_chk u_nfp_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .read_data_o(read_data_o),
  .op_total_o (op_total_o)
);

/* tb/nor_flash_program_erase_model_top_test.sv */
// Self-checking testbench for the NOR flash program/erase emulation block
module nor_flash_program_erase_model_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nfp_pkg::*;

  localparam int unsigned FLASH_BYTES = CAPACITY_DEF;
  localparam int unsigned BURST_MAX   = MAX_BYTES_DEF;
  localparam logic [1:0]  FUNC_UNDEF  = 2'd3;
  localparam logic [63:0] ALL_FF      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          HOLDOFF     = 300;
  localparam int          DRAIN_WAIT  = 64;
  localparam int          PHASE_ITEMS = 204;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [16:0] cnt;
    logic [63:0] wdata;
  } flash_cmd_t;

  typedef struct packed {
    logic        status;
    logic [63:0] rdata;
    logic [31:0] total;
  } flash_resp_t;

  typedef struct packed {
    flash_cmd_t  cmd;
    logic        typed;
    flash_resp_t want;
    logic [1:0]  phase;
  } dir_row_t;

  // Short directed walk; rows with typed=0 are checked against the predictor
  localparam dir_row_t DIR_ROWS [24] = '{
    '{'{FUNC_READ,    16'd0,     17'd8,       64'd0}, 1'b1, '{STATUS_OK,  ALL_FF, 32'd1}, 2'd0},
    '{'{FUNC_READ,    16'd65528, 17'd8,       64'd0}, 1'b1, '{STATUS_OK,  ALL_FF, 32'd2}, 2'd0},
    '{'{FUNC_READ,    16'd65529, 17'd8,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd2}, 2'd0},
    '{'{FUNC_READ,    16'd0,     17'd9,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd2}, 2'd0},
    '{'{FUNC_UNDEF,   16'd0,     17'd1,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd2}, 2'd0},
    '{'{FUNC_READ,    16'd100,   17'd0,       64'd0}, 1'b1, '{STATUS_OK,  64'd0,  32'd3}, 2'd0},
    '{'{FUNC_PROGRAM, 16'd0,     17'd8, 64'h0123_4567_89AB_CDEF}, 1'b1,
      '{STATUS_OK, 64'd0, 32'd4}, 2'd0},
    '{'{FUNC_READ,    16'd0,     17'd8,       64'd0}, 1'b1,
      '{STATUS_OK, 64'h0123_4567_89AB_CDEF, 32'd5}, 2'd0},
    '{'{FUNC_PROGRAM, 16'd0,     17'd1,     64'hFF}, 1'b1, '{STATUS_ERR, 64'd0,  32'd6}, 2'd0},
    '{'{FUNC_PROGRAM, 16'd0,     17'd9,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd6}, 2'd0},
    '{'{FUNC_PROGRAM, 16'd65535, 17'd1,       64'd0}, 1'b1, '{STATUS_OK,  64'd0,  32'd7}, 2'd0},
    '{'{FUNC_ERASE,   16'd65535, 17'd2,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd7}, 2'd0},
    '{'{FUNC_ERASE,   16'd0,     17'd0,       64'd0}, 1'b1, '{STATUS_OK,  64'd0,  32'd8}, 2'd0},
    '{'{FUNC_ERASE,   16'd0,     17'd65536,   64'd0}, 1'b1, '{STATUS_OK,  64'd0,  32'd9}, 2'd0},
    '{'{FUNC_READ,    16'd0,     17'd8,       64'd0}, 1'b1, '{STATUS_OK,  ALL_FF, 32'd10}, 2'd0},
    '{'{FUNC_ERASE,   16'd0,     17'h1FFFF,   64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd10}, 2'd0},
    '{'{FUNC_PROGRAM, 16'd0,     17'd8,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd11}, 2'd1},
    '{'{FUNC_ERASE,   16'd0,     17'd8,       64'd0}, 1'b1, '{STATUS_ERR, 64'd0,  32'd12}, 2'd1},
    '{'{FUNC_READ,    16'd0,     17'd8,       64'd0}, 1'b1, '{STATUS_OK,  ALL_FF, 32'd13}, 2'd1},
    '{'{FUNC_ERASE,   16'd0,     17'd4,       64'd0}, 1'b1, '{STATUS_OK,  64'd0,  32'd14}, 2'd2},
    '{'{FUNC_PROGRAM, 16'd0,     17'd1,     64'hFF}, 1'b1, '{STATUS_OK,  64'd0,  32'd15}, 2'd2},
    '{'{FUNC_PROGRAM, 16'd4,     17'd2,   64'h0F0F}, 1'b1, '{STATUS_OK,  64'd0,  32'd16}, 2'd2},
    '{'{FUNC_READ,    16'd0,     17'd8,       64'd0}, 1'b0, '0, 2'd2},
    '{'{FUNC_READ,    16'd4,     17'd3,       64'd0}, 1'b1,
      '{STATUS_OK, 64'h00FF_0F0F, 32'd18}, 2'd2}
  };

  localparam logic [7:0] DIR_EV     [3] = '{8'hFF, 8'h00, 8'h00};
  localparam logic       DIR_STRICT [3] = '{1'b1, 1'b1, 1'b0};
  localparam logic       DIR_FAIL   [3] = '{1'b0, 1'b1, 1'b0};

  localparam logic [7:0] PH_EV     [8] = '{8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h00, 8'h5A, 8'hFF, 8'hC3};
  localparam logic       PH_STRICT [8] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam logic       PH_FAIL   [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [1:0]          func_i          = FUNC_READ;
  logic [15:0]         start_address_i = '0;
  logic [16:0]         byte_count_i    = '0;
  logic [63:0]         write_data_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                status_o;
  logic [63:0]         read_data_o;
  logic [31:0]         op_total_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  // Predictor state
  logic [7:0]  flash_img [FLASH_BYTES];
  logic [31:0] op_count    = '0;
  logic [7:0]  erase_byte  = ERASED_RESET;
  logic        strict_on   = 1'b1;
  logic        fail_on     = 1'b0;

  flash_resp_t replies_due [$];
  int          mismatches  = 0;
  int          issued      = 0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;

  nor_flash_program_erase_model_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic flash_resp_t flash_apply(input flash_cmd_t c);
    flash_resp_t r;
    int unsigned a;
    int unsigned n;
    logic        bad;
    r = '0;
    a = c.addr;
    n = c.cnt;
    bad = 1'b0;
    if (c.func == FUNC_UNDEF || a + n > FLASH_BYTES || (c.func != FUNC_ERASE && n > BURST_MAX)) begin
      r.status = STATUS_ERR;
    end else begin
      op_count = op_count + 32'd1;
      if (c.func == FUNC_READ) begin
        for (int unsigned i = 0; i < n; i++) r.rdata[8*i +: 8] = flash_img[a+i];
      end else if (fail_on) begin
        r.status = STATUS_ERR;
      end else if (c.func == FUNC_PROGRAM) begin
        if (strict_on) begin
          for (int unsigned i = 0; i < n; i++) begin
            if ((~flash_img[a+i] & c.wdata[8*i +: 8]) != 8'd0) bad = 1'b1;
          end
        end
        if (bad) begin
          r.status = STATUS_ERR;
        end else begin
          for (int unsigned i = 0; i < n; i++) flash_img[a+i] = flash_img[a+i] & c.wdata[8*i +: 8];
        end
      end else begin
        for (int unsigned i = 0; i < n; i++) flash_img[a+i] = erase_byte;
      end
    end
    r.total = op_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t ns: %s differs: got %h, want %h", $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, hold it until taken, then predict its reply
  task automatic issue(input flash_cmd_t c, input bit typed = 1'b0,
                       input flash_resp_t want = '0);
    flash_resp_t model;
    int          gap;
    in_valid_i      <= 1'b1;
    func_i          <= c.func;
    start_address_i <= c.addr;
    byte_count_i    <= c.cnt;
    write_data_i    <= c.wdata;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model = flash_apply(c);
    replies_due.push_back(typed ? want : model);
    issued++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ERASED_VALUE) erase_byte = data;
    else if (idx == CFG_STRICT_PROGRAM) strict_on = data[0];
    else if (idx == CFG_FAIL_INJECT) fail_on = data[0];
  endtask

  task automatic configure(input logic [7:0] ev, input logic strict, input logic fail);
    cfg_write(CFG_ERASED_VALUE, ev);
    cfg_write(CFG_STRICT_PROGRAM, {7'd0, strict});
    cfg_write(CFG_FAIL_INJECT, {7'd0, fail});
    cfg_valid_i <= 1'b0;
  endtask

  // Erase, program, read back, program again and read again over one small range
  task automatic flash_sequence();
    flash_cmd_t c;
    int         n;
    int         base;
    int         ecnt;
    int         r;
    n = $urandom_range(1, BURST_MAX);
    r = $urandom_range(0, 99);
    if (r < 15) base = $urandom_range(0, 16);
    else if (r < 30) base = FLASH_BYTES - n - $urandom_range(0, 16);
    else base = $urandom_range(0, FLASH_BYTES - n);
    ecnt = n;
    if ($urandom_range(0, 99) < 3) begin
      ecnt = $urandom_range(9, 2048);
      if (base + ecnt > FLASH_BYTES) ecnt = FLASH_BYTES - base;
    end
    c = '{FUNC_ERASE, 16'(base), 17'(ecnt), {$urandom, $urandom}};
    issue(c);
    c = '{FUNC_PROGRAM, 16'(base), 17'(n), {$urandom, $urandom}};
    issue(c);
    c = '{FUNC_READ, 16'(base), 17'(n), {$urandom, $urandom}};
    issue(c);
    // Clear-only data passes the strict check; raw random data mostly trips it
    c = '{FUNC_PROGRAM, 16'(base), 17'(n), {$urandom, $urandom}};
    if ($urandom_range(0, 99) < 70) begin
      for (int i = 0; i < n; i++) c.wdata[8*i +: 8] = flash_img[base+i] & 8'($urandom);
    end
    issue(c);
    c = '{FUNC_READ, 16'(base), 17'($urandom_range(0, n)), {$urandom, $urandom}};
    issue(c);
  endtask

  task automatic noise_item();
    flash_cmd_t c;
    c.func  = 2'($urandom_range(0, 3));
    c.addr  = 16'($urandom);
    c.cnt   = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 12)) : 17'($urandom);
    c.wdata = {$urandom, $urandom};
    // Keep stray erases short: push large in-range ones past the top
    if (c.func == FUNC_ERASE && 32'(c.addr) + 32'(c.cnt) <= FLASH_BYTES && c.cnt > 17'd64) begin
      c.cnt = 17'(FLASH_BYTES - c.addr + $urandom_range(1, 1000));
    end
    issue(c);
  endtask

  // Reply checker and receiver stall pattern
  always @(posedge clk_i) begin
    flash_resp_t w;
    int          r;
    int          hold_left;
    int          stall_left;
    int          free_left;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unrequested reply op_total", 64'(op_total_o), 64'd0);
      end else begin
        w = replies_due.pop_front();
        if (status_o !== w.status) report_mismatch("status", 64'(status_o), 64'(w.status));
        if (read_data_o !== w.rdata) report_mismatch("read_data", read_data_o, w.rdata);
        if (op_total_o !== w.total) report_mismatch("op_total", 64'(op_total_o), 64'(w.total));
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLDOFF;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) free_left = $urandom_range(20, 150);
      else if (r < 8) stall_left = $urandom_range(20, 60);
      else if (r < 40) stall_left = $urandom_range(1, 3);
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    int cur_phase;
    int target;
    int waited;
    foreach (flash_img[i]) flash_img[i] = ERASED_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_phase = 0;
    foreach (DIR_ROWS[k]) begin
      if (int'(DIR_ROWS[k].phase) != cur_phase) begin
        drain();
        cur_phase = DIR_ROWS[k].phase;
        configure(DIR_EV[cur_phase], DIR_STRICT[cur_phase], DIR_FAIL[cur_phase]);
      end
      issue(DIR_ROWS[k].cmd, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      configure(PH_EV[p], PH_STRICT[p], PH_FAIL[p]);
      if (p == 1) begin
        // Back up the reply path while requests keep coming
        hold_req   = 1'b1;
        burst_left = 16;
      end
      target = issued + PHASE_ITEMS;
      while (issued < target) begin
        if ($urandom_range(0, 3) == 0) noise_item();
        else flash_sequence();
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (replies_due.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    while (replies_due.size() != 0) begin
      w_left_over: begin
        flash_resp_t lost;
        lost = replies_due.pop_front();
        report_mismatch("missing reply op_total", 64'd0, 64'(lost.total));
      end
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* nor_flash_program_erase_model_top.f */
+incdir+rtl
rtl/nfp_pkg.sv
rtl/nfp_mem.sv
rtl/nor_flash_program_erase_model_top.sv
rtl/nfp_chk.sv
tb/nor_flash_program_erase_model_top_test.sv
